[sv/rtc3w_pkg.sv]
// Types and constants shared by the three-wire clock-chip serial master.
package rtc3w_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned ShiftW  = 2 * DataW;
	localparam int unsigned CountW  = 5;
	localparam int unsigned InTdataW  = 24;
	localparam int unsigned OutTdataW = 16;

	// Last half-bit of each counted stretch
	localparam logic [CountW-1:0] LastHalfWrite = CountW'(31);
	localparam logic [CountW-1:0] LastHalfAddr  = CountW'(15);
	localparam logic [CountW-1:0] LastHalfRead  = CountW'(15);

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_SEND  = 2'd1,
		PH_RECV  = 2'd2,
		PH_CLOSE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [DataW-1:0] address;
		logic [DataW-1:0] write_data;
		logic             io_in;
	} item_t;

	typedef struct packed {
		logic             clock_level;
		logic             enable_level;
		logic             io_out;
		logic             io_drive;
		logic             busy_res;
		logic [DataW-1:0] read_data;
		logic             read_done;
	} result_t;

endpackage

[sv/three_wire_rtc_serial_master.sv]
// Top level of the three-wire clock-chip serial master: stream ports and stage registers.
//
// Each request (a start-write, a start-read or a half-bit tick) gives exactly one result,
// the pin levels and status after that request. Requests go through an input register,
// a combinational update of the transfer state and a result register, so one request is
// taken every clock cycle while the output is not stalled. A write takes one start and
// 33 ticks (32 half bits and a closing tick); a read takes one start and 33 ticks, the
// last one reporting the byte.
// Starts while a transfer runs, ticks while idle and kind 3 leave the state unchanged.
module three_wire_rtc_serial_master
	import rtc3w_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [InTdataW-1:0]  s_tdata,  // address[7:0], write_data[15:8], io_in[16], zero
	input  logic [1:0]           s_tuser,  // kind[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutTdataW-1:0] m_tdata,  // clock_level, enable_level, io_out, io_drive,
	                                       // busy_res, read_data[12:5], zero
	output logic [0:0]           m_tuser   // read_done
);

	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    m_tvalid_q;
	logic    adv;

	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= s_tuser;
			item_s1.address    <= s_tdata[DataW-1:0];
			item_s1.write_data <= s_tdata[2*DataW-1:DataW];
			item_s1.io_in      <= s_tdata[2*DataW];
		end
		if (adv)
			res_q <= res_d;
	end

	rtc3w_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res_d)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.read_data, res_q.busy_res, res_q.io_drive,
		res_q.io_out, res_q.enable_level, res_q.clock_level};
	assign m_tuser  = res_q.read_done;

	// a finished read leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> !m_tdata[4])
		else $error("read_done while still busy");

	// idle means all pins low and line released
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[4]) |-> (m_tdata[3:0] == 4'b0000))
		else $error("pins active while idle");

	// input register stalls only while it holds a request
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without cause");

endmodule

[sv/rtc3w_core.sv]
// Transfer state and per-request update of the three-wire serial master.
module rtc3w_core
	import rtc3w_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  item_t   item,
	output result_t res
);

	phase_t            phase_q, phase_d;
	logic [CountW-1:0] bit_count_q, bit_count_d;
	logic [ShiftW-1:0] out_shift_q, out_shift_d;
	logic [DataW-1:0]  in_shift_q, in_shift_d;
	logic              is_read_q, is_read_d;
	logic              clk_q, clk_d, en_q, en_d, io_q, io_d, drv_q, drv_d;
	logic              done;
	logic              start;
	logic              last_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			is_read_q   <= 1'b0;
			clk_q       <= 1'b0;
			en_q        <= 1'b0;
			io_q        <= 1'b0;
			drv_q       <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			out_shift_q <= out_shift_d;
			in_shift_q  <= in_shift_d;
			is_read_q   <= is_read_d;
			clk_q       <= clk_d;
			en_q        <= en_d;
			io_q        <= io_d;
			drv_q       <= drv_d;
		end
	end

	assign start = (item.kind == KIND_WRITE || item.kind == KIND_READ) &&
		(phase_q == PH_IDLE);

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		is_read_d   = is_read_q;
		clk_d       = clk_q;
		en_d        = en_q;
		io_d        = io_q;
		drv_d       = drv_q;
		done        = 1'b0;
		last_half   = 1'b0;
		if (start) begin
			is_read_d = (item.kind == KIND_READ);
			if (item.kind == KIND_READ) begin
				out_shift_d = {{DataW{1'b0}}, item.address};
				in_shift_d  = '0;
			end else begin
				out_shift_d = {item.write_data, item.address};
			end
			bit_count_d = '0;
			phase_d     = PH_SEND;
			clk_d = 1'b0; en_d = 1'b1; io_d = 1'b0; drv_d = 1'b1;
		end else if (item.kind == KIND_TICK) begin
			unique case (phase_q)
				PH_SEND: begin
					clk_d = bit_count_q[0];
					en_d  = 1'b1;
					drv_d = 1'b1;
					if (!bit_count_q[0]) begin
						io_d = out_shift_q[0];
					end else begin
						out_shift_d = out_shift_q >> 1;
					end
					last_half = is_read_q ? (bit_count_q == LastHalfAddr) :
						(bit_count_q == LastHalfWrite);
					bit_count_d = bit_count_q + 1'b1;
					if (last_half) begin
						bit_count_d = '0;
						phase_d     = is_read_q ? PH_RECV : PH_CLOSE;
					end
				end
				PH_RECV: begin
					clk_d = bit_count_q[0];
					en_d  = 1'b1;
					io_d  = 1'b0;
					drv_d = 1'b0;
					// sample on the clock-low half, least significant bit first
					if (!bit_count_q[0])
						in_shift_d = {item.io_in, in_shift_q[DataW-1:1]};
					bit_count_d = bit_count_q + 1'b1;
					if (bit_count_q == LastHalfRead) begin
						bit_count_d = '0;
						phase_d     = PH_CLOSE;
					end
				end
				PH_CLOSE: begin
					clk_d = 1'b0; en_d = 1'b0; io_d = 1'b0; drv_d = 1'b0;
					done        = is_read_q;
					phase_d     = PH_IDLE;
					bit_count_d = '0;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		res.clock_level  = clk_d;
		res.enable_level = en_d;
		res.io_out       = io_d;
		res.io_drive     = drv_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.read_data    = in_shift_d;
		res.read_done    = done;
	end

endmodule

[sim/rtc_pin_checker.sv]
// Predictor and result checker for the three-wire clock-chip serial master.
module rtc_pin_checker
	import rtc3w_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [InTdataW-1:0]  s_tdata,  // address[7:0], write_data[15:8], io_in[16], zero
	input  logic [1:0]           s_tuser,  // kind[1:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [OutTdataW-1:0] m_tdata,  // clock_level, enable_level, io_out, io_drive,
	                                       // busy_res, read_data[12:5], zero
	input  logic [0:0]           m_tuser,  // read_done
	output int unsigned          mismatches,
	output int unsigned          outstanding,
	output int unsigned          reads_checked
);

	phase_t            xfer_phase;
	logic [CountW-1:0] half_count;
	logic [ShiftW-1:0] tx_bits;
	logic [DataW-1:0]  rx_byte;
	logic              read_xfer;
	logic              pin_clk, pin_en, pin_io, pin_drv;
	result_t           expected_pins[$];

	function automatic void set_pins(input logic c, input logic e, input logic io,
			input logic drv);
		pin_clk = c;
		pin_en  = e;
		pin_io  = io;
		pin_drv = drv;
	endfunction

	// Advance the transfer by one request and give the pin levels it leaves behind
	task automatic step_transfer(input item_t req, output result_t res);
		logic done;
		done = 1'b0;
		if ((req.kind == KIND_WRITE || req.kind == KIND_READ) && xfer_phase == PH_IDLE) begin
			read_xfer = (req.kind == KIND_READ);
			tx_bits   = read_xfer ? {{DataW{1'b0}}, req.address}
			                      : {req.write_data, req.address};
			if (read_xfer)
				rx_byte = '0;
			half_count = '0;
			xfer_phase = PH_SEND;
			set_pins(1'b0, 1'b1, 1'b0, 1'b1);
		end else if (req.kind == KIND_TICK) begin
			case (xfer_phase)
				PH_SEND: begin
					if (!half_count[0]) begin
						set_pins(1'b0, 1'b1, tx_bits[0], 1'b1);
					end else begin
						set_pins(1'b1, 1'b1, pin_io, 1'b1);
						tx_bits = tx_bits >> 1;
					end
					if (half_count == (read_xfer ? LastHalfAddr : LastHalfWrite)) begin
						half_count = '0;
						xfer_phase = read_xfer ? PH_RECV : PH_CLOSE;
					end else begin
						half_count = half_count + 1'b1;
					end
				end
				PH_RECV: begin
					// sample on the low half, line released throughout
					if (!half_count[0]) begin
						set_pins(1'b0, 1'b1, 1'b0, 1'b0);
						rx_byte = {req.io_in, rx_byte[DataW-1:1]};
					end else begin
						set_pins(1'b1, 1'b1, 1'b0, 1'b0);
					end
					if (half_count == LastHalfRead) begin
						half_count = '0;
						xfer_phase = PH_CLOSE;
					end else begin
						half_count = half_count + 1'b1;
					end
				end
				PH_CLOSE: begin
					set_pins(1'b0, 1'b0, 1'b0, 1'b0);
					done       = read_xfer;
					xfer_phase = PH_IDLE;
					half_count = '0;
				end
				default: ;
			endcase
		end
		res.clock_level  = pin_clk;
		res.enable_level = pin_en;
		res.io_out       = pin_io;
		res.io_drive     = pin_drv;
		res.busy_res     = (xfer_phase != PH_IDLE);
		res.read_data    = rx_byte;
		res.read_done    = done;
	endtask

	function automatic void check_field(input string name, input logic [DataW-1:0] want_v,
			input logic [DataW-1:0] seen_v);
		if (seen_v !== want_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want_v, seen_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		item_t   req;
		result_t want;
		result_t seen;
		if (!arst_n) begin
			xfer_phase = PH_IDLE;
			half_count = '0;
			tx_bits    = '0;
			rx_byte    = '0;
			read_xfer  = 1'b0;
			set_pins(1'b0, 1'b0, 1'b0, 1'b0);
			expected_pins.delete();
			mismatches    = 0;
			reads_checked = 0;
			outstanding   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				req.kind       = s_tuser;
				req.address    = s_tdata[DataW-1:0];
				req.write_data = s_tdata[2*DataW-1:DataW];
				req.io_in      = s_tdata[2*DataW];
				step_transfer(req, want);
				expected_pins.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				seen.clock_level  = m_tdata[0];
				seen.enable_level = m_tdata[1];
				seen.io_out       = m_tdata[2];
				seen.io_drive     = m_tdata[3];
				seen.busy_res     = m_tdata[4];
				seen.read_data    = m_tdata[5 +: DataW];
				seen.read_done    = m_tuser[0];
				if (expected_pins.size() == 0) begin
					$display("%0t: result %0h/%0h arrived with nothing expected", $time,
						m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = expected_pins.pop_front();
					check_field("clock_level", DataW'(want.clock_level),
						DataW'(seen.clock_level));
					check_field("enable_level", DataW'(want.enable_level),
						DataW'(seen.enable_level));
					check_field("io_out", DataW'(want.io_out), DataW'(seen.io_out));
					check_field("io_drive", DataW'(want.io_drive), DataW'(seen.io_drive));
					check_field("busy_res", DataW'(want.busy_res), DataW'(seen.busy_res));
					check_field("read_data", want.read_data, seen.read_data);
					check_field("read_done", DataW'(want.read_done),
						DataW'(seen.read_done));
					if (want.read_done && seen.read_done)
						reads_checked++;
				end
			end
			outstanding = expected_pins.size();
		end
	end

endmodule

[sim/testbench.sv]
// Stimulus, stall patterns and verdict for the three-wire clock-chip serial master.
module testbench;
	import rtc3w_pkg::*;

	localparam logic [1:0]  KindReserved  = 2'd3;
	localparam int unsigned TickCount     = 33; // 32 half bits and the closing tick
	localparam int unsigned ItemTarget    = 1150;
	localparam int unsigned HoldOffCycles = 80;
	localparam int unsigned IdleLimit     = 2000;
	localparam int unsigned DrainCycles   = 10;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [InTdataW-1:0]  s_tdata  = '0;
	logic [1:0]           s_tuser  = KIND_TICK;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OutTdataW-1:0] m_tdata;
	logic [0:0]           m_tuser;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned reads_checked;
	int unsigned requests_sent  = 0;
	int unsigned writes_started = 0;
	int unsigned reads_started  = 0;
	int unsigned stray_requests = 0;
	int unsigned gap_max        = 10;
	int unsigned stall_max      = 10;
	int unsigned idle_cycles    = 0;
	int unsigned transfers      = 0;
	bit          hold_off_req   = 1'b0;

	three_wire_rtc_serial_master u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rtc_pin_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.reads_checked (reads_checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Offer one request after a random gap and hold it until taken
	task automatic offer_request(input logic [1:0] kind, input logic [7:0] address,
			input logic [7:0] write_data, input logic io_in);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {7'd0, io_in, write_data, address};
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		requests_sent++;
	endtask

	// One start and its ticks; stray starts and reserved kinds are mixed in at noise_pct
	task automatic run_transfer(input bit read_req, input logic [7:0] address,
			input logic [7:0] write_data, input int unsigned noise_pct,
			input bit io_random, input logic io_level);
		int unsigned n;
		offer_request(read_req ? KIND_READ : KIND_WRITE, address, write_data,
			1'($urandom_range(0, 1)));
		if (read_req)
			reads_started++;
		else
			writes_started++;
		for (n = 0; n < TickCount; n++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				offer_request(2'($urandom_range(KIND_WRITE, KindReserved)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				stray_requests++;
			end
			offer_request(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				io_random ? 1'($urandom_range(0, 1)) : io_level);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned n;
		int unsigned cut;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick and reserved kind change nothing
		offer_request(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
		offer_request(KindReserved, 8'hFF, 8'hFF, 1'b1);
		// write of extreme bytes, with a read start and a reserved kind while busy
		offer_request(KIND_WRITE, 8'hFF, 8'h00, 1'b0);
		writes_started++;
		offer_request(KIND_READ, 8'h00, 8'hFF, 1'b1);
		offer_request(KindReserved, 8'h00, 8'h00, 1'b0);
		for (n = 0; n < TickCount; n++)
			offer_request(KIND_TICK, 8'h00, 8'h00, 1'b0);
		// read with the line held high, so every sampled bit is one
		run_transfer(1'b1, 8'h00, 8'hFF, 0, 1'b0, 1'b1);

		while (requests_sent < ItemTarget) begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			if (transfers == 4) begin
				// back to back while the output is held off, so the input stalls
				gap_max      = 0;
				hold_off_req = 1'b1;
			end
			if (transfers == 9)
				drain_results();
			if ($urandom_range(0, 99) < 85) begin
				run_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8, 1'b1, 1'b0);
			end else if ($urandom_range(0, 1) == 0) begin
				// cut short or overlong: leftover ticks land in whatever phase follows
				offer_request($urandom_range(0, 1) ? KIND_READ : KIND_WRITE,
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
				stray_requests++;
				cut = $urandom_range(0, 40);
				for (n = 0; n < cut; n++)
					offer_request(KIND_TICK, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				offer_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				stray_requests++;
			end
			transfers++;
		end

		drain_results();
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d requests: %0d write and %0d read transfers, %0d stray or cut items.",
			requests_sent, writes_started, reads_started, stray_requests);
		$display("Checked %0d completed reads, across one long output hold-off and a mid-run drain.",
			reads_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : result_sink
		int unsigned pause;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				pause = $urandom_range(0, stall_max);
				if (pause != 0) begin
					m_tready <= 1'b0;
					repeat (pause) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IdleLimit) begin
			$display("%0t: nothing moved on either side for %0d cycles", $time, IdleLimit);
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

[sim.f]
sv/rtc3w_pkg.sv
sv/rtc3w_core.sv
sv/three_wire_rtc_serial_master.sv
sim/rtc_pin_checker.sv
sim/testbench.sv
